// File: hdl/swq_pkg.sv
`default_nettype none
package swq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;

  localparam int ID_W     = 8;
  localparam int PRIO_W   = 8;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = ID_W + PRIO_W;

  localparam logic [OP_W-1:0] OP_WAIT     = 2'd0;
  localparam logic [OP_W-1:0] OP_REL_ONE  = 2'd1;
  localparam logic [OP_W-1:0] OP_REL_ALL  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic                load;
    logic [ID_W-1:0]     id;
    logic [STATUS_W-1:0] status;
    logic                last;
  } res_t;

  // logical queue position to ram address, wrapping around the ring
  function automatic logic [ADDR_W-1:0] ring_addr(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0]  idx);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(idx);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/sync_wait_queue.sv
// Wait queue of a synchronization object, up to swq_pkg::QUEUE_DEPTH tasks.
// Input stream: in_tuser is the opcode (wait, release one, release all),
// in_tdata carries task id and priority value. Each wait or release gives
// one result on the output stream, release all gives one per queued task,
// with out_tlast on the final one. out_tuser is the status, out_tdata the id.
// cfg_wr_en/cfg_wr_data set the release mode: 0 arrival order, 1 ascending
// priority value, equal values in arrival order; write only while idle.
// One request is worked on at a time; in_tready is low meanwhile.
// An enqueue in arrival order or into an empty queue, and an empty or full
// case, go straight to the result; in_tready returns once it is loaded. A
// priority enqueue scans, then ripples, the ring memory one entry per cycle.
// Release drains one entry per cycle while the output register is free,
// after a registered read of the head. The ring memory has a single read
// and a single write port. The result sits in an output register: a stalled
// receiver holds it and the sequencer waits, nothing is lost. Reset empties
// the queue and sets arrival order mode; memory contents are not cleared.
`default_nettype none
module sync_wait_queue (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic                               cfg_wr_data,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [swq_pkg::ENTRY_W-1:0]        in_tdata,   // task_id, task_priority
  input  wire logic [swq_pkg::OP_W-1:0]           in_tuser,   // opcode
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [swq_pkg::ID_W-1:0]                out_tdata,  // released_id
  output logic [swq_pkg::STATUS_W-1:0]            out_tuser,  // status
  output logic                                    out_tlast
);

  swq_pkg::res_t                   res;
  logic                            slot_free;
  logic                            ram_wr_en;
  logic [swq_pkg::ADDR_W-1:0]      ram_wr_addr;
  logic [swq_pkg::ADDR_W-1:0]      ram_rd_addr;
  swq_pkg::entry_t                 ram_wr_data;
  swq_pkg::entry_t                 ram_rd_data;
  logic [swq_pkg::ENTRY_W-1:0]     ram_rd_bits;

  logic                            out_valid_r;
  logic [swq_pkg::ID_W-1:0]        out_id_r;
  logic [swq_pkg::STATUS_W-1:0]    out_status_r;
  logic                            out_last_r;

  assign slot_free   = !out_valid_r || out_tready;
  assign ram_rd_data = swq_pkg::entry_t'(ram_rd_bits);

  swq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_opcode   (in_tuser),
    .in_id       (in_tdata[swq_pkg::ID_W-1:0]),
    .in_prio     (in_tdata[swq_pkg::ENTRY_W-1:swq_pkg::ID_W]),
    .slot_free   (slot_free),
    .res         (res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  swq_ram #(
    .WIDTH (swq_pkg::ENTRY_W),
    .DEPTH (swq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_bits)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_id_r     <= res.id;
      out_status_r <= res.status;
      out_last_r   <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// File: hdl/swq_ram.sv
`default_nettype none
module swq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: hdl/swq_ctrl.sv
`default_nettype none
module swq_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic                           cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [swq_pkg::OP_W-1:0]       in_opcode,
  input  wire logic [swq_pkg::ID_W-1:0]       in_id,
  input  wire logic [swq_pkg::PRIO_W-1:0]     in_prio,
  input  wire logic                           slot_free,
  output swq_pkg::res_t                       res,
  output logic                                ram_wr_en,
  output logic [swq_pkg::ADDR_W-1:0]          ram_wr_addr,
  output swq_pkg::entry_t                     ram_wr_data,
  output logic [swq_pkg::ADDR_W-1:0]          ram_rd_addr,
  input  wire swq_pkg::entry_t                ram_rd_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_POP   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            mode_r, mode_nxt;
  logic [swq_pkg::ADDR_W-1:0]      head_r, head_nxt;
  logic [swq_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [swq_pkg::CNT_W-1:0]       idx_r, idx_nxt;
  logic [swq_pkg::OP_W-1:0]        op_r, op_nxt;
  logic [swq_pkg::ID_W-1:0]        id_r, id_nxt;
  logic [swq_pkg::PRIO_W-1:0]      prio_r, prio_nxt;
  swq_pkg::entry_t                 carry_r, carry_nxt;
  logic [swq_pkg::ID_W-1:0]        res_id_r, res_id_nxt;
  logic [swq_pkg::STATUS_W-1:0]    res_status_r, res_status_nxt;

  logic                            accept;
  logic                            full;
  logic                            prio_gt;
  logic [swq_pkg::CNT_W-1:0]       idx_inc;
  logic [swq_pkg::CNT_W-1:0]       wr_idx;
  logic [swq_pkg::ADDR_W-1:0]      head_inc;

  assign in_ready = (state_r == S_IDLE) && rst_n;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == swq_pkg::CNT_W'(swq_pkg::QUEUE_DEPTH));
  assign idx_inc  = idx_r + swq_pkg::CNT_W'(1);
  assign head_inc = (head_r == swq_pkg::ADDR_W'(swq_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : head_r + swq_pkg::ADDR_W'(1);

  // compare unit for the priority scan
  assign prio_gt = (ram_rd_data.prio > prio_r);

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = cfg_wr_en ? cfg_wr_data : mode_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    prio_nxt       = prio_r;
    carry_nxt      = carry_r;
    res_id_nxt     = res_id_r;
    res_status_nxt = res_status_r;
    ram_wr_en      = 1'b0;
    wr_idx         = count_r;
    ram_wr_data    = '{prio: prio_r, id: id_r};
    res            = '{load: 1'b0, id: res_id_r, status: res_status_r, last: 1'b1};

    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          op_nxt   = in_opcode;
          id_nxt   = in_id;
          prio_nxt = in_prio;
          unique case (in_opcode)
            swq_pkg::OP_WAIT: begin
              res_id_nxt = in_id;
              if (full) begin
                res_status_nxt = swq_pkg::ST_FULL;
                state_nxt      = S_EMIT;
              end else if (!mode_r || count_r == '0) begin
                ram_wr_en      = 1'b1;
                ram_wr_data    = '{prio: in_prio, id: in_id};
                count_nxt      = count_r + swq_pkg::CNT_W'(1);
                res_status_nxt = swq_pkg::ST_ENQUEUED;
                state_nxt      = S_EMIT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            swq_pkg::OP_REL_ONE, swq_pkg::OP_REL_ALL: begin
              if (count_r == '0) begin
                res_id_nxt     = '0;
                res_status_nxt = swq_pkg::ST_EMPTY;
                state_nxt      = S_EMIT;
              end else begin
                state_nxt = S_POP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        res_id_nxt     = id_r;
        res_status_nxt = swq_pkg::ST_ENQUEUED;
        if (prio_gt) begin
          ram_wr_en = 1'b1;
          wr_idx    = idx_r;
          carry_nxt = ram_rd_data;
          idx_nxt   = idx_inc;
          state_nxt = S_SHIFT;
        end else if (idx_inc == count_r) begin
          ram_wr_en = 1'b1;
          wr_idx    = count_r;
          count_nxt = count_r + swq_pkg::CNT_W'(1);
          state_nxt = S_EMIT;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      S_SHIFT: begin
        ram_wr_en   = 1'b1;
        wr_idx      = idx_r;
        ram_wr_data = carry_r;
        if (idx_r == count_r) begin
          count_nxt = count_r + swq_pkg::CNT_W'(1);
          state_nxt = S_EMIT;
        end else begin
          carry_nxt = ram_rd_data;
          idx_nxt   = idx_inc;
        end
      end
      S_POP: begin
        if (slot_free) begin
          res.load   = 1'b1;
          res.id     = ram_rd_data.id;
          res.status = swq_pkg::ST_RELEASED;
          res.last   = (op_r == swq_pkg::OP_REL_ONE) || (count_r == swq_pkg::CNT_W'(1));
          head_nxt   = head_inc;
          count_nxt  = count_r - swq_pkg::CNT_W'(1);
          if (res.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          res.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ram_wr_addr = swq_pkg::ring_addr(head_r, wr_idx);
  assign ram_rd_addr = swq_pkg::ring_addr(head_nxt, idx_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= 1'b0;
      head_r  <= '0;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    prio_r       <= prio_nxt;
    carry_r      <= carry_nxt;
    res_id_r     <= res_id_nxt;
    res_status_r <= res_status_nxt;
  end

endmodule
`default_nettype wire

// File: hdl/swq_checker.sv
`default_nettype none
module swq_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [swq_pkg::OP_W-1:0]        in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [swq_pkg::ID_W-1:0]        out_tdata,
  input wire logic [swq_pkg::STATUS_W-1:0]    out_tuser,
  input wire logic                            out_tlast
);

  // a real request drops input ready in the cycle after it is accepted
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == swq_pkg::OP_WAIT ||
      in_tuser == swq_pkg::OP_REL_ONE || in_tuser == swq_pkg::OP_REL_ALL)
    |=> !in_tready)
    else $error("input ready right after a request");

  // results other than releases are single and final
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != swq_pkg::ST_RELEASED |-> out_tlast)
    else $error("non-release result without last");

  // an empty report carries no id
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == swq_pkg::ST_EMPTY |-> out_tdata == '0)
    else $error("empty result with nonzero id");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped under stall");

endmodule

bind sync_wait_queue swq_checker u_swq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

// File: tb/sync_wait_queue_tb.sv
`default_nettype none
module sync_wait_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swq_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 4000;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [STATUS_W-1:0] status;
    logic                last;
  } wake_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_wr_data = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [ENTRY_W-1:0]  in_tdata = '0;    // task_id, task_priority
  logic [OP_W-1:0]     in_tuser = '0;    // opcode
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [ID_W-1:0]     out_tdata;        // released_id
  logic [STATUS_W-1:0] out_tuser;        // status
  logic                out_tlast;

  entry_t waiters[$];
  wake_t  awaited_wakeups[$];
  logic   prio_order = 1'b0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     error_count = 0;
  int     stall_cycles = 0;

  sync_wait_queue DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // wait queue behavior for one accepted request
  task automatic model_wait_queue(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                  input logic [PRIO_W-1:0] prio);
    int     pos;
    entry_t ent;
    case (op)
      OP_WAIT: begin
        if (waiters.size() >= QUEUE_DEPTH) begin
          awaited_wakeups.push_back('{id: id, status: ST_FULL, last: 1'b1});
        end else begin
          pos = waiters.size();
          if (prio_order) begin
            for (int i = 0; i < waiters.size(); i++) begin
              if (waiters[i].prio > prio) begin
                pos = i;
                break;
              end
            end
          end
          ent.id = id;
          ent.prio = prio;
          waiters.insert(pos, ent);
          awaited_wakeups.push_back('{id: id, status: ST_ENQUEUED, last: 1'b1});
        end
      end
      OP_REL_ONE, OP_REL_ALL: begin
        if (waiters.size() == 0) begin
          awaited_wakeups.push_back('{id: '0, status: ST_EMPTY, last: 1'b1});
        end else if (op == OP_REL_ONE) begin
          ent = waiters.pop_front();
          awaited_wakeups.push_back('{id: ent.id, status: ST_RELEASED, last: 1'b1});
        end else begin
          while (waiters.size() > 0) begin
            ent = waiters.pop_front();
            awaited_wakeups.push_back('{id: ent.id, status: ST_RELEASED,
                                        last: (waiters.size() == 0)});
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  always @(posedge clk) begin
    wake_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_wakeups.size() == 0) begin
        report_mismatch("unexpected result id", out_tdata, -1);
      end else begin
        want = awaited_wakeups.pop_front();
        if (out_tdata !== want.id) report_mismatch("released_id", out_tdata, want.id);
        if (out_tuser !== want.status) report_mismatch("status", out_tuser, want.status);
        if (out_tlast !== want.last) report_mismatch("last", out_tlast, want.last);
      end
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                              input logic [PRIO_W-1:0] prio);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {prio, id};
    do @(posedge clk); while (!in_tready);
    model_wait_queue(op, id, prio);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (awaited_wakeups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_release_mode(input logic mode);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    prio_order = mode;
  endtask

  function automatic logic [PRIO_W-1:0] random_priority();
    // narrow range half the time so equal values are common
    if ($urandom_range(1)) return PRIO_W'($urandom_range(3));
    return PRIO_W'($urandom_range(255));
  endfunction

  task automatic test_fifo_order();
    set_release_mode(1'b0);
    send_request(OP_REL_ONE, 8'hff, 8'hff);
    send_request(OP_REL_ALL, 8'hff, 8'h00);
    send_request(OP_UNUSED, 8'h5a, 8'ha5);
    send_request(OP_WAIT, 8'h00, 8'hff);
    send_request(OP_WAIT, 8'hff, 8'h00);
    send_request(OP_REL_ONE, 8'h00, 8'h00);
    send_request(OP_REL_ALL, 8'h00, 8'hff);
  endtask

  task automatic test_priority_order();
    set_release_mode(1'b1);
    send_request(OP_WAIT, 8'h11, 8'd7);
    send_request(OP_WAIT, 8'h12, 8'd7);
    send_request(OP_WAIT, 8'h13, 8'd0);
    send_request(OP_WAIT, 8'h14, 8'd255);
    send_request(OP_WAIT, 8'h15, 8'd7);
  endtask

  // entries keep their order across the mode change, then fill and overflow
  task automatic test_mode_switch_full();
    set_release_mode(1'b0);
    for (int i = 0; i < QUEUE_DEPTH - 5; i++) begin
      send_request(OP_WAIT, ID_W'(8'h20 + i), PRIO_W'(8'hf0 - i));
    end
    send_request(OP_WAIT, 8'hee, 8'h01);
    send_request(OP_REL_ALL, 8'h33, 8'hcc);
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
                                     input logic mode);
    int sent;
    int burst;
    int pick;
    set_release_mode(mode);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        burst = $urandom_range(18, 12);
        repeat (burst) send_request(OP_WAIT, ID_W'($urandom_range(255)), random_priority());
        sent += burst;
      end else begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          send_request(OP_WAIT, ID_W'($urandom_range(255)), random_priority());
          sent++;
        end else if (pick < 80) begin
          send_request(OP_REL_ONE, ID_W'($urandom_range(255)), PRIO_W'($urandom_range(255)));
          sent++;
        end else if (pick < 92) begin
          send_request(OP_REL_ALL, ID_W'($urandom_range(255)), PRIO_W'($urandom_range(255)));
          sent++;
        end else begin
          send_request(OP_UNUSED, ID_W'($urandom_range(255)), PRIO_W'($urandom_range(255)));
        end
      end
    end
    settle();
  endtask

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    send_idle_pct = 26;
    recv_idle_pct = 77;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fifo_order();
    test_priority_order();
    test_mode_switch_full();
    test_random_traffic(45, 26, 77, 1'b1);
    test_random_traffic(45, 77, 26, 1'b0);
    test_random_traffic(45, 0, 0, 1'b1);
    if (awaited_wakeups.size() != 0) begin
      report_mismatch("results still awaited", 0, awaited_wakeups.size());
    end
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
hdl/swq_pkg.sv
hdl/swq_ram.sv
hdl/swq_ctrl.sv
hdl/sync_wait_queue.sv
hdl/swq_checker.sv
tb/sync_wait_queue_tb.sv
